FILE: src/rmra_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmra_pkg : rate monotonic rank assignment, shared definitions
// Field widths, action codes and the payload and memory request types.
// ----------------------------------------------------------------------------
package rmra_pkg;

    localparam int SLOT_W    = 4;
    localparam int PERIOD_W  = 32;
    localparam int RANK_W    = 5;
    localparam int SLOT_SPAN = 16;

    localparam logic ACT_INSERT  = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    localparam logic [RANK_W-1:0] RANK_ONE = RANK_W'(1);

    typedef struct packed {
        logic                action;
        logic [SLOT_W-1:0]   slot;
        logic [PERIOD_W-1:0] period;
        logic                task_dormant;
    } t_task_item;

    typedef struct packed {
        logic [SLOT_W-1:0] out_slot;
        logic [RANK_W-1:0] rank;
        logic              last;
    } t_rank_item;

    typedef struct packed {
        logic                wr_en;
        logic [SLOT_W-1:0]   wr_addr;
        logic [PERIOD_W-1:0] wr_data;
        logic [SLOT_W-1:0]   rd_addr_a;
        logic [SLOT_W-1:0]   rd_addr_b;
    } t_mem_req;

endpackage
`default_nettype wire

FILE: src/rmra_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmra_if : rate monotonic rank assignment, channel interfaces
// Valid/ready channels for task transactions and rank result transactions.
// ----------------------------------------------------------------------------
interface rmra_task_if;
    import rmra_pkg::*;

    logic       valid;
    logic       ready;
    t_task_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rmra_rank_if;
    import rmra_pkg::*;

    logic       valid;
    logic       ready;
    t_rank_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/rmra_slot_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmra_slot_mem : task period memory
// One write port and two registered read ports over the slot periods.
// ----------------------------------------------------------------------------
module rmra_slot_mem #(
    parameter int DEPTH = 16
) (
    input  wire logic                           i_clk,
    input  wire rmra_pkg::t_mem_req             i_req,
    output logic [rmra_pkg::PERIOD_W-1:0]       o_rd_data_a,
    output logic [rmra_pkg::PERIOD_W-1:0]       o_rd_data_b
);
    import rmra_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [PERIOD_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr[AW-1:0]] <= i_req.wr_data;
        end
        o_rd_data_a <= r_mem[i_req.rd_addr_a[AW-1:0]];
        o_rd_data_b <= r_mem[i_req.rd_addr_b[AW-1:0]];
    end

endmodule
`default_nettype wire

FILE: src/rmra_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmra_seq : rank sequencer
// Tracks slot use, walks each used slot against every slot through one shared
// period comparator and registers one rank result transaction per used slot.
// ----------------------------------------------------------------------------
module rmra_seq #(
    parameter int MAX_TASKS = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    rmra_task_if.sink                     i_task,
    rmra_rank_if.source                   o_rank,
    output rmra_pkg::t_mem_req            o_mem_req,
    input  wire logic [rmra_pkg::PERIOD_W-1:0] i_rd_data_a,
    input  wire logic [rmra_pkg::PERIOD_W-1:0] i_rd_data_b
);
    import rmra_pkg::*;

    localparam int DEPTH = (MAX_TASKS < SLOT_SPAN) ? MAX_TASKS : SLOT_SPAN;
    localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROW,
        S_SCAN,
        S_DRAIN,
        S_EMIT
    } t_state;

    t_state            r_state;
    logic [DEPTH-1:0]  r_used;
    logic [IW-1:0]     r_i;
    logic [IW-1:0]     r_j;
    logic [RANK_W-1:0] r_rank;
    logic              r_cmp_vld;
    logic              r_cmp_en;
    logic              r_out_vld;
    t_rank_item        r_out;

    logic          w_accept;
    logic          w_slot_ok;
    logic [IW-1:0] w_slot;
    logic          w_hit;
    logic          w_above;
    logic          w_out_free;

    assign i_task.ready = (r_state == S_IDLE);
    assign w_accept     = i_task.valid && i_task.ready;
    assign w_slot_ok    = int'(i_task.data.slot) < MAX_TASKS;
    assign w_slot       = i_task.data.slot[IW-1:0];
    assign w_hit        = r_cmp_vld && r_cmp_en && (i_rd_data_b > i_rd_data_a);
    assign w_out_free   = !r_out_vld || o_rank.ready;

    assign o_rank.valid = r_out_vld;
    assign o_rank.data  = r_out;

    always_comb begin
        o_mem_req.wr_en     = w_accept && w_slot_ok
                              && (i_task.data.action == ACT_INSERT)
                              && i_task.data.task_dormant
                              && (i_task.data.period != '0);
        o_mem_req.wr_addr   = i_task.data.slot;
        o_mem_req.wr_data   = i_task.data.period;
        o_mem_req.rd_addr_a = SLOT_W'(r_i);
        o_mem_req.rd_addr_b = SLOT_W'(r_j);
    end

    always_comb begin
        w_above = 1'b0;
        for (int k = 0; k < DEPTH; k++) begin
            if (r_used[k] && (IW'(k) > r_i)) begin
                w_above = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_used    <= '0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (r_out_vld && o_rank.ready) begin
                r_out_vld <= 1'b0;
            end
            r_cmp_vld <= 1'b0;
            if (w_hit) begin
                r_rank <= r_rank + RANK_ONE;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept && w_slot_ok) begin
                        if (i_task.data.action == ACT_RELEASE) begin
                            r_used[w_slot] <= 1'b0;
                        end else if (o_mem_req.wr_en) begin
                            r_used[w_slot] <= 1'b1;
                            r_i            <= '0;
                            r_state        <= S_ROW;
                        end
                    end
                end
                S_ROW: begin
                    if (r_used[r_i]) begin
                        r_j     <= '0;
                        r_rank  <= RANK_ONE;
                        r_state <= S_SCAN;
                    end else if (r_i == LAST_IDX) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_i <= r_i + IW'(1);
                    end
                end
                S_SCAN: begin
                    r_cmp_vld <= 1'b1;
                    r_cmp_en  <= r_used[r_j];
                    if (r_j == LAST_IDX) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_j <= r_j + IW'(1);
                    end
                end
                S_DRAIN: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_vld      <= 1'b1;
                        r_out.out_slot <= SLOT_W'(r_i);
                        r_out.rank     <= r_rank;
                        r_out.last     <= !w_above;
                        if (!w_above) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_i     <= r_i + IW'(1);
                            r_state <= S_ROW;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: src/rate_monotonic_rank_assign_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rate_monotonic_rank_assign_core : rate monotonic rank assignment
// Slot table of task periods; an insert re-ranks every used slot.
// ----------------------------------------------------------------------------
// A release or a rejected insert is taken in the idle state and leaves the
// input ready. An accepted insert walks the D = min(MAX_TASKS, 16) slots row
// by row and can be held in its emit state by output stalls. One period
// comparator with a two-port period memory is walked over each used slot
// paired with every slot, one pair per cycle within a row. Input is not
// ready during that walk; the final result sits in an output register while
// the next transaction enters.
module rate_monotonic_rank_assign_core #(
    parameter int MAX_TASKS = 16
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    rmra_task_if.sink   i_task,
    rmra_rank_if.source o_rank
);
    import rmra_pkg::*;

    localparam int DEPTH = (MAX_TASKS < SLOT_SPAN) ? MAX_TASKS : SLOT_SPAN;

    t_mem_req            w_mem_req;
    logic [PERIOD_W-1:0] w_rd_data_a;
    logic [PERIOD_W-1:0] w_rd_data_b;

    rmra_seq #(
        .MAX_TASKS (MAX_TASKS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_task      (i_task),
        .o_rank      (o_rank),
        .o_mem_req   (w_mem_req),
        .i_rd_data_a (w_rd_data_a),
        .i_rd_data_b (w_rd_data_b)
    );

    rmra_slot_mem #(
        .DEPTH (DEPTH)
    ) u_slot_mem (
        .i_clk       (i_clk),
        .i_req       (w_mem_req),
        .o_rd_data_a (w_rd_data_a),
        .o_rd_data_b (w_rd_data_b)
    );

endmodule
`default_nettype wire

FILE: test/rate_monotonic_rank_assign_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rate_monotonic_rank_assign_core_tb : rank assignment core testbench
// Drives task transactions (inserts, releases, rejected inserts) into the
// core and checks every rank transaction against a slot table model kept
// alongside. Runs three handshake phases with varying idle rates, one long
// receiver hold-off and a drain between phases.
// ----------------------------------------------------------------------------
module rate_monotonic_rank_assign_core_tb;
    import rmra_pkg::*;

    localparam int          MAX_TASKS       = 16;
    localparam int          CLK_PERIOD      = 8;
    localparam int          RESET_CYCLES    = 9;
    localparam int          RANDOM_PER_PASS = 90;
    localparam int          NUM_PASSES      = 3;
    localparam int          HOLD_TRIGGER    = 40;
    localparam int          HOLD_CYCLES     = 1500;
    localparam int          TAIL_CYCLES     = 400;
    localparam int          CYCLE_LIMIT     = 1000000;
    localparam logic [31:0] PERIOD_MAX      = 32'hFFFF_FFFF;

    logic i_clk;
    logic i_rst_n;

    rmra_task_if task_ch ();
    rmra_rank_if rank_ch ();

    rate_monotonic_rank_assign_core #(
        .MAX_TASKS (MAX_TASKS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_task  (task_ch),
        .o_rank  (rank_ch)
    );

    t_task_item          task_pending_q[$];
    t_rank_item          rank_expect_q[$];
    logic [PERIOD_W-1:0] slot_period_m[SLOT_SPAN];
    logic                slot_used_m[SLOT_SPAN];

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int tasks_accepted     = 0;
    int hold_left          = 0;
    bit hold_done          = 1'b0;
    int error_count        = 0;
    int cycle_count        = 0;

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        task_ch.valid = 1'b0;
        task_ch.data  = '0;
        rank_ch.ready = 1'b0;
        for (int i = 0; i < SLOT_SPAN; i++) begin
            slot_period_m[i] = '0;
            slot_used_m[i]   = 1'b0;
        end
    end

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    function automatic t_task_item make_task(input logic act, input int slot,
                                             input logic [PERIOD_W-1:0] period,
                                             input logic dormant);
        t_task_item it;
        it.action       = act;
        it.slot         = SLOT_W'(slot);
        it.period       = period;
        it.task_dormant = dormant;
        return it;
    endfunction

    // mostly well-formed inserts and releases; small periods force rank ties
    function automatic t_task_item random_task();
        t_task_item          it;
        logic [PERIOD_W-1:0] period;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: period = PERIOD_W'($urandom_range(1, 8));
            4:          period = PERIOD_MAX;
            5:          period = PERIOD_W'(1);
            6:          period = '0;
            default:    period = $urandom;
        endcase
        it.action       = ($urandom_range(0, 99) < 25) ? ACT_RELEASE : ACT_INSERT;
        it.slot         = SLOT_W'($urandom_range(0, SLOT_SPAN - 1));
        it.period       = period;
        it.task_dormant = ($urandom_range(0, 99) < 88);
        return it;
    endfunction

    task automatic rank_table_apply(input t_task_item it);
        int          last_slot;
        int          longer;
        int          slot_top;
        t_rank_item  res;
        slot_top = (MAX_TASKS < SLOT_SPAN) ? MAX_TASKS : SLOT_SPAN;
        if (int'(it.slot) >= MAX_TASKS) begin
            return;
        end
        if (it.action == ACT_RELEASE) begin
            slot_used_m[it.slot]   = 1'b0;
            slot_period_m[it.slot] = '0;
            return;
        end
        if (!it.task_dormant || it.period == '0) begin
            return;
        end
        slot_period_m[it.slot] = it.period;
        slot_used_m[it.slot]   = 1'b1;
        last_slot = 0;
        for (int i = 0; i < slot_top; i++) begin
            if (slot_used_m[i]) begin
                last_slot = i;
            end
        end
        for (int i = 0; i < slot_top; i++) begin
            if (slot_used_m[i]) begin
                longer = 0;
                for (int j = 0; j < slot_top; j++) begin
                    if (slot_used_m[j] && slot_period_m[j] > slot_period_m[i]) begin
                        longer++;
                    end
                end
                res.out_slot = SLOT_W'(i);
                res.rank     = RANK_ONE + RANK_W'(longer);
                res.last     = (i == last_slot);
                rank_expect_q.push_back(res);
            end
        end
    endtask

    always @(posedge i_clk) begin : task_driver
        logic offer;
        if (!i_rst_n) begin
            task_ch.valid <= 1'b0;
        end else begin
            offer = task_ch.valid && !task_ch.ready;
            if (task_ch.valid && task_ch.ready) begin
                rank_table_apply(task_ch.data);
                tasks_accepted <= tasks_accepted + 1;
            end
            if (!offer && task_pending_q.size() != 0
                    && $urandom_range(0, 99) >= sender_idle_pct) begin
                task_ch.data <= task_pending_q.pop_front();
                offer = 1'b1;
            end
            task_ch.valid <= offer;
        end
    end

    always @(posedge i_clk) begin : rank_ready_gen
        if (!i_rst_n) begin
            rank_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            rank_ch.ready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (!hold_done && tasks_accepted >= HOLD_TRIGGER) begin
            rank_ch.ready <= 1'b0;
            hold_left     <= HOLD_CYCLES;
            hold_done     <= 1'b1;
        end else begin
            rank_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    always @(posedge i_clk) begin : rank_monitor
        t_rank_item want;
        t_rank_item got;
        if (i_rst_n && rank_ch.valid && rank_ch.ready) begin
            got = rank_ch.data;
            if (rank_expect_q.size() == 0) begin
                error_count++;
                $display("%0t: unexpected rank transaction slot %0d rank %0d last %0d",
                         $time, got.out_slot, got.rank, got.last);
            end else begin
                want = rank_expect_q.pop_front();
                if (got.out_slot !== want.out_slot) begin
                    error_count++;
                    $display("%0t: out_slot expected %0d, got %0d",
                             $time, want.out_slot, got.out_slot);
                end
                if (got.rank !== want.rank) begin
                    error_count++;
                    $display("%0t: rank of slot %0d expected %0d, got %0d",
                             $time, want.out_slot, want.rank, got.rank);
                end
                if (got.last !== want.last) begin
                    error_count++;
                    $display("%0t: last of slot %0d expected %0d, got %0d",
                             $time, want.out_slot, want.last, got.last);
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        wait (i_rst_n === 1'b1);
        for (int pass = 0; pass < NUM_PASSES; pass++) begin
            case (pass)
                0: begin
                    sender_idle_pct    = 17;
                    receiver_stall_pct = 46;
                end
                1: begin
                    sender_idle_pct    = 46;
                    receiver_stall_pct = 17;
                end
                default: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
            endcase
            if (pass == 0) begin
                task_pending_q.push_back(make_task(ACT_RELEASE, 3, PERIOD_MAX, 1'b1));
                task_pending_q.push_back(make_task(ACT_INSERT, 0, '0, 1'b1));
                task_pending_q.push_back(make_task(ACT_INSERT, 0, 32'd10, 1'b0));
                task_pending_q.push_back(make_task(ACT_INSERT, 0, PERIOD_MAX, 1'b1));
                task_pending_q.push_back(make_task(ACT_INSERT, 15, 32'd1, 1'b1));
                task_pending_q.push_back(make_task(ACT_INSERT, 7, 32'd1, 1'b1));
                task_pending_q.push_back(make_task(ACT_INSERT, 0, 32'd1, 1'b1));
                task_pending_q.push_back(make_task(ACT_RELEASE, 7, '0, 1'b0));
                task_pending_q.push_back(make_task(ACT_RELEASE, 7, '0, 1'b0));
                // fill every slot, with ties and the longest period
                for (int s = 0; s < SLOT_SPAN; s++) begin
                    task_pending_q.push_back(make_task(ACT_INSERT, s,
                        (s % 5 == 0) ? PERIOD_MAX : PERIOD_W'((s * 7) % 5 + 1), 1'b1));
                end
            end
            for (int n = 0; n < RANDOM_PER_PASS; n++) begin
                task_pending_q.push_back(random_task());
            end
            // hold the sender until every result of this pass has drained
            do begin
                @(negedge i_clk);
            end while (task_pending_q.size() != 0 || task_ch.valid
                       || rank_expect_q.size() != 0);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0 && rank_expect_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
